// ----- hdl/kiss8_pkg.sv -----
// ----------------------------------------------------------------------------
// kiss8_pkg
// Types, constants and step functions shared by the KISS-style 8-bit random
// generator: state record, byte step and four-byte word step.
// ----------------------------------------------------------------------------
`default_nettype none

package kiss8_pkg;

   // Command codes carried in the cmd field of a request.
   localparam logic CmdReseed = 1'b0;
   localparam logic CmdNext   = 1'b1;

   // Generator constants.
   localparam logic [7:0] WeylIncrement    = 8'd151;
   localparam int         DefaultWarmupWords = 32;
   localparam int         BytesPerWord     = 4;

   typedef logic [7:0] byte_type;

   // Full generator state.
   typedef struct packed {
      byte_type [3:0] xs;      // xorshift register, index 0 is the oldest byte
      byte_type [2:0] awc;     // add-with-carry lag bytes
      logic           carry;   // add-with-carry carry bit
      byte_type       weyl;    // Weyl sequence byte
   } kiss8_state_type;

   // Result of one word step: the state after four bytes and the word.
   typedef struct packed {
      kiss8_state_type st;
      logic [31:0]     word;
   } kiss8_step_type;

   // State after reset and after the xorshift part of a reseed.
   localparam kiss8_state_type ResetState = '{
      xs:    {8'd1, 8'd0, 8'd0, 8'd0},
      awc:   '0,
      carry: 1'b1,
      weyl:  8'd0
   };

   // One byte step of all three parts. The generated byte is returned in
   // the low byte of the result; the new state sits above it.
   function automatic logic [$bits(kiss8_state_type)+7:0] byte_step(
      input kiss8_state_type st
   );
      kiss8_state_type nx;
      byte_type        tx;
      byte_type        top;
      logic [8:0]      sum;
      byte_type        out_byte;
      tx  = st.xs[0] ^ {st.xs[0][3:0], 4'b0000};
      top = st.xs[3];
      nx.xs[0] = st.xs[1];
      nx.xs[1] = st.xs[2];
      nx.xs[2] = top;
      nx.xs[3] = top ^ tx ^ {1'b0, top[7:1]} ^ {tx[6:0], 1'b0};
      sum = {1'b0, st.awc[0]} + {1'b0, st.awc[1]} + {8'd0, st.carry};
      nx.awc[0] = st.awc[1];
      nx.awc[1] = st.awc[2];
      nx.awc[2] = sum[7:0];
      nx.carry  = sum[8];
      nx.weyl   = st.weyl + WeylIncrement;
      out_byte  = nx.xs[0] + nx.awc[2] + nx.weyl;
      return {nx, out_byte};
   endfunction

   // Four chained byte steps; the first byte lands in bits 7:0.
   function automatic kiss8_step_type word_step(input kiss8_state_type st);
      kiss8_step_type                      res;
      logic [$bits(kiss8_state_type)+7:0]  bs;
      res.st   = st;
      res.word = '0;
      for (int k = 0; k < BytesPerWord; k++) begin
         bs = byte_step(res.st);
         res.st = bs[$bits(kiss8_state_type)+7:8];
         res.word[8*k +: 8] = bs[7:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/kiss8_req_if.sv -----
// ----------------------------------------------------------------------------
// kiss8_req_if
// Request channel of the generator: valid/ready handshake with command and
// seed payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface kiss8_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [31:0] seed;

   modport source (output valid, output cmd, output seed, input ready);
   modport sink   (input valid, input cmd, input seed, output ready);
endinterface

`default_nettype wire

// ----- hdl/kiss8_rsp_if.sv -----
// ----------------------------------------------------------------------------
// kiss8_rsp_if
// Response channel of the generator: valid/ready handshake with one 32-bit
// random word.
// ----------------------------------------------------------------------------
`default_nettype none

interface kiss8_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

`default_nettype wire

// ----- hdl/kiss8_awc_random_generator_core.sv -----
// ----------------------------------------------------------------------------
// kiss8_awc_random_generator_core
// KISS-style 8-bit combined random generator (xorshift, add-with-carry and
// Weyl parts) producing one 32-bit word per next command.
// ----------------------------------------------------------------------------
//
// Channel    Direction  Payload               Transaction
// req_chan   in         cmd, seed[31:0]       reseed (cmd 0) or next word (cmd 1)
// rsp_chan   out        word[31:0]            one word per next command
//
// A next command is taken every cycle while req_chan.ready is high; its word
// is registered in the output buffer, which holds two entries (response
// register plus skid register) and lets a request be taken while a word
// waits on the output. A reseed produces no response and keeps
// req_chan.ready low while the warm-up words run through the step logic.
// Reset is synchronous and active high; after it the block is ready at once.
`default_nettype none

module kiss8_awc_random_generator_core
   import kiss8_pkg::*;
#(
   parameter int WARMUP_WORDS = DefaultWarmupWords
) (
   input  wire             clock,
   input  wire             reset,
   kiss8_req_if.sink       req_chan,
   kiss8_rsp_if.source     rsp_chan
);

   localparam int CountWidth = (WARMUP_WORDS > 0) ? $clog2(WARMUP_WORDS + 1) : 1;
   localparam logic [CountWidth-1:0] WarmupLoad = CountWidth'(WARMUP_WORDS);

   kiss8_state_type          state_ff, state_in;
   logic [CountWidth-1:0]    warm_cnt_ff, warm_cnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [31:0]              rsp_word_ff, rsp_word_in;
   logic                     skid_valid_ff, skid_valid_in;
   logic [31:0]              skid_word_ff, skid_word_in;

   kiss8_step_type           step;
   logic                     warming;
   logic                     req_take;
   logic                     push;
   logic                     pop;

   // Word step from the current state, shared by warm-up and next commands.
   assign step     = word_step(state_ff);
   assign warming  = (warm_cnt_ff != '0);

   // Handshake decode.
   assign req_chan.ready = !warming && !skid_valid_ff;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign push           = req_take && (req_chan.cmd == CmdNext);
   assign pop            = rsp_valid_ff && rsp_chan.ready;

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.word  = rsp_word_ff;

   // Generator state and warm-up counter.
   always_comb begin
      state_in    = state_ff;
      warm_cnt_in = warm_cnt_ff;
      if (warming) begin
         state_in    = step.st;
         warm_cnt_in = warm_cnt_ff - 1'b1;
      end else if (req_take) begin
         if (req_chan.cmd == CmdReseed) begin
            state_in       = ResetState;
            state_in.awc   = {req_chan.seed[23:16], req_chan.seed[15:8], req_chan.seed[7:0]};
            state_in.carry = (req_chan.seed[23:0] == 24'd0);
            state_in.weyl  = req_chan.seed[31:24];
            warm_cnt_in    = WarmupLoad;
         end else begin
            state_in = step.st;
         end
      end
   end

   // Output buffer: response register with a skid register behind it.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_word_in   = rsp_word_ff;
      skid_valid_in = skid_valid_ff;
      skid_word_in  = skid_word_ff;
      if (push) begin
         if (!rsp_valid_ff || pop) begin
            rsp_valid_in = 1'b1;
            rsp_word_in  = step.word;
         end else begin
            skid_valid_in = 1'b1;
            skid_word_in  = step.word;
         end
      end else if (pop) begin
         if (skid_valid_ff) begin
            rsp_word_in   = skid_word_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ResetState;
         warm_cnt_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         warm_cnt_ff   <= warm_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rsp_word_ff  <= rsp_word_in;
      skid_word_ff <= skid_word_in;
   end

   // The skid register only ever holds a word behind a full response register.
   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register valid while response register empty");

   // No request is taken while warm-up words are running.
   a_no_take_in_warmup: assert property (@(posedge clock) disable iff (reset)
      warming |-> !req_chan.ready)
      else $error("request channel ready during warm-up");

   // A reseed starts a full warm-up run.
   a_reseed_loads_count: assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_chan.cmd == CmdReseed)) |=> (warm_cnt_ff == WarmupLoad))
      else $error("warm-up counter not loaded by reseed");

   // A next word taken while the output stalls lands in the skid register.
   a_stall_fills_skid: assert property (@(posedge clock) disable iff (reset)
      (push && rsp_valid_ff && !rsp_chan.ready) |=> skid_valid_ff)
      else $error("stalled word lost instead of held in skid register");

   // A reseed never produces a response.
   a_reseed_silent: assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_chan.cmd == CmdReseed) && !rsp_valid_ff) |=> !rsp_valid_ff)
      else $error("response produced for a reseed");

endmodule

`default_nettype wire
